// ----- rtl/core/dsha_pkg.sv -----
// ----------------------------------------------------------------------------
// dsha_pkg - shared types, constants and functions for the double SHA-256 check
// Holds the round constants, the initial value and the round and schedule helpers.
// ----------------------------------------------------------------------------
package dsha_pkg;

	localparam int NumRounds = 64;
	localparam int NumBlocks = 3;

	localparam logic [1:0] STATUS_TOP_NONZERO = 2'd0;
	localparam logic [1:0] STATUS_NOT_BELOW   = 2'd1;
	localparam logic [1:0] STATUS_BELOW       = 2'd2;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] hstate_t;
	typedef word_t [15:0] sched_t;

	localparam hstate_t INIT_VALUE = '{
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic word_t round_k(input logic [5:0] t);
		word_t k;
		begin
			case (t)
				6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
				6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
				6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
				6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
				6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
				6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
				6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
				6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
				6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
				6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
				6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
				6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
				6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
				6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
				6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
				6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
				6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
				6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
				6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
				6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
				6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
				default: k = 32'hc67178f2;
			endcase
			return k;
		end
	endfunction

	function automatic word_t ror32(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t swap_bytes(input word_t x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	// One compression round on the working variables, index 0 is a.
	function automatic hstate_t sha_round(input hstate_t v, input word_t kw);
		word_t big1, ch, t1, big0, maj;
		hstate_t r;
		begin
			big1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
			ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
			t1   = v[7] + big1 + ch + kw;
			big0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
			maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			r[7] = v[6];
			r[6] = v[5];
			r[5] = v[4];
			r[4] = v[3] + t1;
			r[3] = v[2];
			r[2] = v[1];
			r[1] = v[0];
			r[0] = t1 + big0 + maj;
			return r;
		end
	endfunction

	// Slide the 16-word schedule window by one word.
	function automatic sched_t sched_next(input sched_t w);
		word_t s0, s1;
		sched_t r;
		begin
			s0 = ror32(w[1], 7) ^ ror32(w[1], 18) ^ (w[1] >> 3);
			s1 = ror32(w[14], 17) ^ ror32(w[14], 19) ^ (w[14] >> 10);
			for (int i = 0; i < 15; i++) r[i] = w[i + 1];
			r[15] = w[0] + s0 + w[9] + s1;
			return r;
		end
	endfunction

	typedef struct packed {
		hstate_t init;
		hstate_t work;
		sched_t  w;
	} cstage_t;

endpackage

// ----- rtl/core/dsha_compress.sv -----
// ----------------------------------------------------------------------------
// dsha_compress - one SHA-256 compression unrolled into 64 round stages
// One round and one schedule step per stage; the feed-forward add is registered last.
// ----------------------------------------------------------------------------
module dsha_compress (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  dsha_pkg::hstate_t in_state,
	input  dsha_pkg::sched_t  in_block,
	input  dsha_pkg::sched_t  in_side,
	output logic              out_vld,
	output dsha_pkg::hstate_t out_state,
	output dsha_pkg::sched_t  out_side
);
	import dsha_pkg::*;

	cstage_t st_s1   [1:NumRounds];
	sched_t  side_s1 [1:NumRounds];
	logic    vld_s1  [1:NumRounds];
	logic    vld_q;
	hstate_t sum_q;
	sched_t  side_q;

	for (genvar g = 0; g < NumRounds; g++) begin : g_round
		logic    vld_d;
		cstage_t st_d;
		sched_t  side_d;

		if (g == 0) begin : g_head
			assign vld_d  = in_vld;
			assign st_d   = '{init: in_state, work: in_state, w: in_block};
			assign side_d = in_side;
		end else begin : g_body
			assign vld_d  = vld_s1[g];
			assign st_d   = st_s1[g];
			assign side_d = side_s1[g];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[g+1] <= 1'b0;
			end else begin
				vld_s1[g+1] <= vld_d;
			end
		end

		always_ff @(posedge clk) begin
			st_s1[g+1].init <= st_d.init;
			st_s1[g+1].work <= sha_round(st_d.work, round_k(6'(g)) + st_d.w[0]);
			st_s1[g+1].w    <= sched_next(st_d.w);
			side_s1[g+1]    <= side_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_s1[NumRounds];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 8; i++)
			sum_q[i] <= st_s1[NumRounds].init[i] + st_s1[NumRounds].work[i];
		side_q <= side_s1[NumRounds];
	end

	assign out_vld   = vld_q;
	assign out_state = sum_q;
	assign out_side  = side_q;
endmodule

// ----- rtl/core/double_sha256_target_check.sv -----
// ----------------------------------------------------------------------------
// double_sha256_target_check - pipelined double SHA-256 share check
// Hashes an 80-byte header twice and compares the digest with a target.
// ----------------------------------------------------------------------------
//  channel   | signals                               | direction
//  ----------+---------------------------------------+----------
//  request   | start, busy, header_words_*           | in (busy is out)
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data | in (cfg_ready is out)
//  result    | done, share_status                    | out
//
// Takes one request per cycle; busy is always low. Each compression is 64 round
// stages plus a feed-forward stage; three in a row plus the compare stage make
// up the pipeline. Reset clears the valid bits and the target.
// The receiver cannot stall, so nothing ever holds; done pulses for one cycle.
module double_sha256_target_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] header_words_0_1,
	input  logic [63:0] header_words_2_3,
	input  logic [63:0] header_words_4_5,
	input  logic [63:0] header_words_6_7,
	input  logic [63:0] header_words_8_9,
	input  logic [63:0] header_words_10_11,
	input  logic [63:0] header_words_12_13,
	input  logic [63:0] header_words_14_15,
	input  logic [63:0] header_words_16_17,
	input  logic [63:0] header_words_18_19,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic        done,
	output logic [1:0]  share_status
);
	import dsha_pkg::*;

	localparam logic [1:0] REG_T01 = 2'd0;
	localparam logic [1:0] REG_T23 = 2'd1;
	localparam logic [1:0] REG_T45 = 2'd2;
	localparam logic [1:0] REG_T6  = 2'd3;

	word_t [6:0] target_q;
	sched_t blk1, side1, blk2, blk3;
	hstate_t mid, dig1, dig2;
	sched_t side2, side3, unused3;
	logic v2, v3, v4;
	logic done_q;
	logic [1:0] status_q;
	word_t dg [8];
	logic [1:0] cmp;

	// Never hold off a request: the pipeline takes one every cycle.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_T01: target_q[1:0] <= cfg_data;
				REG_T23: target_q[3:2] <= cfg_data;
				REG_T45: target_q[5:4] <= cfg_data;
				REG_T6:  target_q[6]   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// First block: header words 0..15. Carry words 16..19 alongside.
	assign blk1 = {header_words_14_15, header_words_12_13, header_words_10_11,
		header_words_8_9, header_words_6_7, header_words_4_5,
		header_words_2_3, header_words_0_1};
	assign side1 = {384'd0, header_words_18_19, header_words_16_17};

	dsha_compress u_c1 (
		.clk(clk), .arst_n(arst_n), .in_vld(start && !busy), .in_state(INIT_VALUE),
		.in_block(blk1), .in_side(side1), .out_vld(v2), .out_state(mid),
		.out_side(side2)
	);

	// Second block: words 16..19 with fixed padding and a length of 640 bits.
	always_comb begin
		blk2 = '0;
		for (int i = 0; i < 4; i++) blk2[i] = side2[i];
		blk2[4]  = 32'h80000000;
		blk2[15] = 32'h00000280;
	end

	dsha_compress u_c2 (
		.clk(clk), .arst_n(arst_n), .in_vld(v2), .in_state(mid),
		.in_block(blk2), .in_side('0), .out_vld(v3), .out_state(dig1),
		.out_side(side3)
	);

	// Outer hash over the 256-bit digest, length 256 bits.
	always_comb begin
		blk3 = '0;
		for (int i = 0; i < 8; i++) blk3[i] = dig1[i];
		blk3[8]  = 32'h80000000;
		blk3[15] = 32'h00000100;
	end

	dsha_compress u_c3 (
		.clk(clk), .arst_n(arst_n), .in_vld(v3), .in_state(INIT_VALUE),
		.in_block(blk3), .in_side(side3), .out_vld(v4), .out_state(dig2),
		.out_side(unused3)
	);

	// Byte-reverse and compare word by word from word 0 up; the highest differing word decides.
	always_comb begin
		for (int i = 0; i < 8; i++) dg[i] = swap_bytes(dig2[i]);
		cmp = STATUS_NOT_BELOW;
		for (int j = 0; j < 7; j++) begin
			if (dg[j] > target_q[j]) cmp = STATUS_NOT_BELOW;
			else if (dg[j] < target_q[j]) cmp = STATUS_BELOW;
		end
		if (dg[7] != 32'd0 || unused3 != '0) cmp = STATUS_TOP_NONZERO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v4;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= cmp;
	end

	assign done         = done_q;
	assign share_status = status_q;

	a_no_status3: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> share_status != 2'd3) else $error("status 3 produced");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v4 |=> done) else $error("result lost");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v4)) else $error("spurious result");
endmodule
